// ----- hw/rtl/ibh_pkg.sv -----
// shared types, constants and modular multiply for the idea block hash
`default_nettype none

package ibh_pkg;

    localparam logic [31:0] SEED0     = 32'h4a7f2e61;
    localparam logic [31:0] SEED1     = 32'h9d3f80c5;
    localparam logic [63:0] HASH_INIT = 64'h2b3c5a7d4f9b8a6c;
    localparam int unsigned LAST_RND  = 8;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    typedef struct packed {
        logic load_byte;
        logic start;
        logic step;
        logic finish;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_full;
        logic cnt_zero;
        logic last;
    } dp_stat_t;

    // multiplication modulo 65537, zero stands for 65536
    function automatic logic [15:0] mul_mod(input logic [15:0] x, input logic [15:0] y);
        logic [16:0] a;
        logic [16:0] b;
        logic [33:0] p;
        logic [17:0] lo;
        logic [17:0] hi;
        logic [17:0] r;
        a  = {(x == 16'd0), x};
        b  = {(y == 16'd0), y};
        p  = a * b;
        lo = {2'b00, p[15:0]};
        hi = {1'b0, p[32:16]};
        if (lo >= hi)
        begin
            r = lo - hi;
        end
        else
        begin
            r = lo + (18'd65537 - hi);
        end
        return r[15:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ibh_datapath.sv -----
// block gathering, key schedule, shared multiplier and chain registers
`default_nettype none

module ibh_datapath
    import ibh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire logic [7:0]  byte_value,
    output dp_stat_t         stat,
    output logic [63:0]      hash_value
);

    logic [63:0]  chain_reg;
    logic [63:0]  block_reg;
    logic [2:0]   count_reg;
    logic [127:0] key_reg;
    logic [1:0]   pair_reg;
    logic [3:0]   rnd_reg;
    logic [1:0]   ph_reg;
    logic [15:0]  x0_reg, x1_reg, x2_reg, x3_reg;
    logic [15:0]  t0_reg;
    logic [15:0]  kh_reg;
    logic [63:0]  hash_reg;

    logic [63:0]  block_next;
    logic [63:0]  merged;
    logic [15:0]  ka, kb;
    logic [15:0]  mul_a, mul_b, mul_p;
    logic [15:0]  t2;
    logic [63:0]  result;

    assign merged     = block_reg | ({56'd0, byte_value} << {count_reg, 3'b000});
    assign block_next = cmd.load_byte ? merged : block_reg;
    assign ka         = key_reg[127:112];
    assign kb         = key_reg[111:96];

    always_comb
    begin
        mul_a = x0_reg;
        mul_b = ka;
        unique case (ph_reg)
            2'd0:
            begin
                mul_a = x0_reg;
                mul_b = ka;
            end
            2'd1:
            begin
                mul_a = x3_reg;
                mul_b = kb;
            end
            2'd2:
            begin
                mul_a = x0_reg ^ x2_reg;
                mul_b = ka;
            end
            2'd3:
            begin
                mul_a = (x1_reg ^ x3_reg) + t0_reg;
                mul_b = kh_reg;
            end
            default:
            begin
                mul_a = x0_reg;
                mul_b = ka;
            end
        endcase
    end

    assign mul_p  = mul_mod(mul_a, mul_b);
    assign t2     = t0_reg + mul_p;
    assign result = cmd.finish ? ({x0_reg, x1_reg, x2_reg, x3_reg} ^ block_reg) : chain_reg;

    assign stat.cnt_full = (count_reg == 3'd7);
    assign stat.cnt_zero = (count_reg == 3'd0);
    assign stat.last     = (rnd_reg == 4'(LAST_RND)) && (ph_reg == 2'd1);
    assign hash_value    = hash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= HASH_INIT;
            block_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.load_byte)
            begin
                block_reg <= merged;
                count_reg <= count_reg + 3'd1;
            end
            if (cmd.finish)
            begin
                block_reg <= '0;
                count_reg <= '0;
            end
            if (cmd.emit)
            begin
                chain_reg <= HASH_INIT;
            end
            else if (cmd.finish)
            begin
                chain_reg <= result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            hash_reg <= result;
        end
        if (cmd.start)
        begin
            key_reg  <= {SEED0, chain_reg[31:0], SEED1, chain_reg[63:32]};
            pair_reg <= '0;
            rnd_reg  <= '0;
            ph_reg   <= '0;
            x0_reg   <= block_next[63:48];
            x1_reg   <= block_next[47:32];
            x2_reg   <= block_next[31:16];
            x3_reg   <= block_next[15:0];
        end
        else if (cmd.step)
        begin
            if (ph_reg != 2'd3)
            begin
                pair_reg <= pair_reg + 2'd1;
                if (pair_reg == 2'd3)
                begin
                    key_reg <= {key_reg[70:0], key_reg[127:71]};
                end
                else
                begin
                    key_reg <= {key_reg[95:0], key_reg[127:96]};
                end
            end
            if (rnd_reg == 4'(LAST_RND))
            begin
                ph_reg <= ph_reg + 2'd1;
                if (ph_reg == 2'd0)
                begin
                    x0_reg <= mul_p;
                    x1_reg <= x2_reg + kb;
                    x2_reg <= x1_reg;
                end
                else
                begin
                    x2_reg <= x2_reg + ka;
                    x3_reg <= mul_p;
                end
            end
            else
            begin
                ph_reg <= ph_reg + 2'd1;
                unique case (ph_reg)
                    2'd0:
                    begin
                        x0_reg <= mul_p;
                        x1_reg <= x1_reg + kb;
                    end
                    2'd1:
                    begin
                        x2_reg <= x2_reg + ka;
                        x3_reg <= mul_p;
                    end
                    2'd2:
                    begin
                        t0_reg <= mul_p;
                        kh_reg <= kb;
                    end
                    2'd3:
                    begin
                        x0_reg  <= x0_reg ^ mul_p;
                        x1_reg  <= x2_reg ^ mul_p;
                        x2_reg  <= x1_reg ^ t2;
                        x3_reg  <= x3_reg ^ t2;
                        rnd_reg <= rnd_reg + 4'd1;
                    end
                    default:
                    begin
                        x0_reg <= x0_reg;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ibh_ctrl.sv -----
// handshake and sequencing state machine for the idea block hash
`default_nettype none

module ibh_ctrl
    import ibh_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire logic     kind,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   emit_reg, emit_next;
    logic   ov_reg, ov_next;
    logic   acc;

    assign in_ready  = (state_reg == S_IDLE) && (!ov_reg || !kind);
    assign acc       = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        emit_next  = emit_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (!kind)
                    begin
                        cmd.load_byte = 1'b1;
                        if (stat.cnt_full)
                        begin
                            cmd.start  = 1'b1;
                            emit_next  = 1'b0;
                            state_next = S_RUN;
                        end
                    end
                    else if (!stat.cnt_zero)
                    begin
                        cmd.start  = 1'b1;
                        emit_next  = 1'b1;
                        state_next = S_RUN;
                    end
                    else
                    begin
                        cmd.emit = 1'b1;
                        ov_next  = 1'b1;
                    end
                end
            end
            S_RUN:
            begin
                cmd.step = 1'b1;
                if (stat.last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                cmd.emit   = emit_reg;
                if (emit_reg)
                begin
                    ov_next = 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            emit_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            emit_reg  <= emit_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/idea_block_hash.sv -----
// top level of the idea block hash
//
//  channel | signals                         | direction
//  in      | in_valid in_ready kind byte_value | request in
//  out     | out_valid out_ready hash_value  | request out
//
// a byte request is taken while the block is idle; the eighth byte of a block,
// or an end request with a partial block, starts the cipher: 8 rounds on one
// shared modulo 65537 multiplier, then the output transform and a finish step,
// after which the next request is taken
// reset is asynchronous; chain returns to its initial value
// byte requests are taken while a hash waits on out; an end request stalls until it leaves
`default_nettype none

module idea_block_hash
    import ibh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [7:0]  byte_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      hash_value
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ibh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ibh_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .byte_value (byte_value),
        .stat       (stat),
        .hash_value (hash_value)
    );

endmodule

`default_nettype wire
